// ===== rtl/core/elg_pkg.sv =====
package elg_pkg;

    // register indexes on the configuration port
    localparam logic [0:0] REG_MODULUS   = 1'b0;
    localparam logic [0:0] REG_GENERATOR = 1'b1;

    // item opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // request to the modular multiplier
    typedef struct packed {
        logic start;
    } t_mul_ctl;

    // status back from the modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage

// ===== rtl/core/elg_modmul.sv =====
// bit-serial modular multiply: result = a * b mod p, one bit of b per cycle
// a and b may be up to 2^W-1; a is reduced first by a serial shift-add pass over its bits
module elg_modmul #(
    parameter int W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  elg_pkg::t_mul_ctl i_ctl,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    input  logic [W-1:0]     i_p,
    output elg_pkg::t_mul_sts o_sts,
    output logic [W-1:0]     o_res
);

    localparam int CW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RED  = 3'b010,
        S_MUL  = 3'b100
    } t_state;

    t_state         r_state, n_state;
    logic [W-1:0]   r_a, n_a;
    logic [W-1:0]   r_b, n_b;
    logic [W-1:0]   r_acc, n_acc;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_done, n_done;

    logic [W:0]     w_dbl;
    logic [W:0]     w_dbl_red;
    logic [W-1:0]   w_dbl_m;
    logic [W:0]     w_add;
    logic [W-1:0]   w_out;

    // doubling step of the accumulator, then conditional add of a
    assign w_dbl     = {r_acc, 1'b0};
    assign w_dbl_red = (w_dbl >= {1'b0, i_p}) ? w_dbl - {1'b0, i_p} : w_dbl;
    assign w_dbl_m   = w_dbl_red[W-1:0];
    assign w_add     = {1'b0, w_dbl_m} + {1'b0, r_a};
    assign w_out     = r_b[W-1]
                       ? ((w_add >= {1'b0, i_p}) ? W'(w_add - {1'b0, i_p}) : w_add[W-1:0])
                       : w_dbl_m;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_a     = i_a;
                    n_b     = i_b;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                // a < 2^W and p >= 2: repeated subtract is bounded, use one step
                // per cycle only while a >= p (at most 2^W/p steps) is too slow,
                // so reduce a by the same shift-add over its bits instead
                if (r_cnt == CW'(W)) begin
                    n_a     = r_acc;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    // acc = (2*acc + bit) mod p, walking a msb first
                    n_acc = ((({1'b0, w_dbl_m} + (W+1)'(r_a[W-1])) >= {1'b0, i_p})
                             ? W'({1'b0, w_dbl_m} + (W+1)'(r_a[W-1]) - {1'b0, i_p})
                             : W'({1'b0, w_dbl_m} + (W+1)'(r_a[W-1])));
                    n_a   = {r_a[W-2:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                if (r_cnt == CW'(W)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_acc = w_out;
                    n_b   = {r_b[W-2:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = r_done;
    assign o_res      = r_acc;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("done outside idle");
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_acc < i_p)
        else $error("product not reduced");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_ctl.start) |=> r_state == S_RED)
        else $error("start not taken");

endmodule

// ===== rtl/core/elg_divstep.sv =====
// restoring divider, one quotient bit per cycle: q = n / d, r = n mod d
module elg_divstep #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_n,
    input  logic [W-1:0] i_d,
    output logic         o_done,
    output logic [W-1:0] o_q,
    output logic [W-1:0] o_r
);

    localparam int CW = $clog2(W + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [W-1:0]   r_q;
    logic [W-1:0]   r_r;
    logic [W-1:0]   r_d;
    logic [W:0]     w_trial;

    assign w_trial = {r_r, r_q[W-1]};

    // shift in one dividend bit, subtract where it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_n;
            r_r <= '0;
            r_d <= i_d;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_d}) begin
                r_r <= W'(w_trial - {1'b0, r_d});
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_r <= w_trial[W-1:0];
                r_q <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_r;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_r < r_d || r_d == '0))
        else $error("remainder out of range");
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_cnt == '0)
        else $error("divider count not cleared");

endmodule

// ===== rtl/core/elgamal_encrypt_decrypt_top.sv =====
// ElGamal encrypt/decrypt engine over a WORD_BITS modulus. Program modulus
// (0x0) and generator (0x4) over APB while idle, then send one word per item.
// Encrypt: shared = key^k, c1 = g^k, c2 = shared*message, all mod p. Decrypt:
// shared = c1^x, inverse by extended Euclid, plaintext = c2*inverse mod p, with
// no_inverse set and plaintext 0 when gcd(shared, p) != 1. A modulus below two
// gives an all-zero result. One item at a time; all products go through one
// bit-serial modular multiplier and every Euclid quotient through a bit-serial
// divider. An encrypt takes 4*WORD_BITS+1 products; a decrypt 2*WORD_BITS+1
// products plus up to ~1.5*WORD_BITS Euclid steps, each step one divide and
// one serial product for the coefficient update. A finished word waits in the
// output register while the next item is taken.
module elgamal_encrypt_decrypt_top #(
    parameter int WORD_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_opcode,
    input  logic [WORD_BITS-1:0] i_key_value,
    input  logic [WORD_BITS-1:0] i_message,
    input  logic [WORD_BITS-1:0] i_ephemeral,
    input  logic [WORD_BITS-1:0] i_cipher_first_in,
    input  logic [WORD_BITS-1:0] i_cipher_second_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_BITS-1:0] o_cipher_first_out,
    output logic [WORD_BITS-1:0] o_cipher_second_out,
    output logic [WORD_BITS-1:0] o_shared_key,
    output logic [WORD_BITS-1:0] o_plaintext,
    output logic                 o_no_inverse
);

    localparam int W  = WORD_BITS;
    localparam int EW = $clog2(W + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PMUL  = 10'b0000000010, // exponent loop: issue a product
        S_PWAIT = 10'b0000000100,
        S_NEXT  = 10'b0000001000, // pick next exponent pass
        S_EDIV  = 10'b0000010000, // euclid: quotient
        S_EDWT  = 10'b0000100000,
        S_EMUL  = 10'b0001000000, // euclid: q*t1 mod p
        S_EMWT  = 10'b0010000000,
        S_FIN   = 10'b0100000000, // final product
        S_OUT   = 10'b1000000000
    } t_state;

    // configuration
    logic [W-1:0] r_mod, r_gen;
    logic         w_wr;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(2);
            r_gen <= W'(2);
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == elg_pkg::REG_MODULUS)
                r_mod <= pwdata[W-1:0];
            else
                r_gen <= pwdata[W-1:0];
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == elg_pkg::REG_MODULUS)
                prdata = 32'(r_mod);
            else
                prdata = 32'(r_gen);
        end
    end

    t_state        r_state;
    logic          r_op;
    logic [1:0]    r_pass;     // 0: key^k / c1^x, 1: g^k, 2: final product
    logic [W-1:0]  r_msg, r_eph, r_c2;
    logic [W-1:0]  r_sq, r_accp, r_exp;
    logic [EW-1:0] r_ecnt;
    logic          r_phase;    // 0 multiply acc, 1 square
    logic [W-1:0]  r_s, r_c1o, r_c2o, r_pto;
    logic          r_nio;
    logic [W-1:0]  r_r0, r_r1, r_t0, r_t1, r_qt;
    logic [W-1:0]  r_o1, r_o2, r_osh, r_opt;
    logic          r_oni, r_valid;

    // shared multiplier
    elg_pkg::t_mul_ctl w_mctl;
    elg_pkg::t_mul_sts w_msts;
    logic [W-1:0]      w_ma, w_mb, w_mres;

    elg_modmul #(.W(W)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_mctl),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .i_p    (r_mod),
        .o_sts  (w_msts),
        .o_res  (w_mres)
    );

    logic         w_dstart, w_ddone;
    logic [W-1:0] w_dq, w_dr;

    elg_divstep #(.W(W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_n    (r_r0),
        .i_d    (r_r1),
        .o_done (w_ddone),
        .o_q    (w_dq),
        .o_r    (w_dr)
    );

    assign w_dstart = (r_state == S_EDIV);

    // operand selection for the multiplier
    always_comb begin
        w_mctl.start = 1'b0;
        w_ma = r_sq;
        w_mb = r_sq;
        unique case (r_state)
            S_PMUL: begin
                w_mctl.start = 1'b1;
                if (!r_phase) begin
                    w_ma = r_accp;
                    w_mb = r_sq;
                end
            end
            S_EMUL: begin
                w_mctl.start = 1'b1;
                w_ma = r_qt;
                w_mb = r_t1;
            end
            S_FIN: begin
                // no final product when the shared secret has no inverse
                w_mctl.start = !(r_op == elg_pkg::OP_DECRYPT && r_r0 != W'(1));
                w_ma = r_op ? r_c2 : r_msg;
                w_mb = r_op ? r_t0 : r_s;
            end
            default: ;
        endcase
    end

    // t0 - q*t1 mod p, both residues
    logic [W:0] w_tsub;
    assign w_tsub = {1'b0, r_t0} + {1'b0, r_mod} - {1'b0, w_mres};

    // item sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            // output word register
            if (r_state == S_OUT)
                r_valid <= 1'b1;
            else if (i_ready)
                r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_opcode;
                        r_msg <= i_message;
                        r_eph <= i_ephemeral;
                        r_c2  <= i_cipher_second_in;
                        r_pass <= '0;
                        r_c1o <= '0;
                        if (r_mod < W'(2)) begin
                            r_s   <= '0;
                            r_c2o <= '0;
                            r_pto <= '0;
                            r_nio <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            // first pass: key^k or c1^x; sq = base, reduced by product
                            r_sq    <= (i_opcode == elg_pkg::OP_DECRYPT)
                                       ? i_cipher_first_in : i_key_value;
                            r_exp   <= (i_opcode == elg_pkg::OP_DECRYPT)
                                       ? i_key_value : i_ephemeral;
                            r_accp  <= W'(1);
                            r_ecnt  <= '0;
                            r_phase <= 1'b0;
                            r_state <= S_PMUL;
                        end
                    end
                end
                S_PMUL: r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (w_msts.done) begin
                        if (r_pass == 2'd2) begin
                            // final product completion
                            r_c2o   <= r_op ? '0 : w_mres;
                            r_pto   <= r_op ? w_mres : '0;
                            r_nio   <= 1'b0;
                            r_state <= S_OUT;
                        end else if (!r_phase) begin
                            if (r_exp[0]) r_accp <= w_mres;
                            r_phase <= 1'b1;
                            r_state <= S_PMUL;
                        end else begin
                            r_sq    <= w_mres;
                            r_exp   <= {1'b0, r_exp[W-1:1]};
                            r_phase <= 1'b0;
                            r_ecnt  <= r_ecnt + 1'b1;
                            r_state <= (r_ecnt == EW'(W - 1)) ? S_NEXT : S_PMUL;
                        end
                    end
                end
                S_NEXT: begin
                    // exponent 1 with unreduced base still yields base mod p via product
                    if (r_pass == 2'd0) begin
                        r_s <= r_accp;
                        if (!r_op) begin
                            r_pass  <= 2'd1;
                            r_sq    <= r_gen;
                            r_exp   <= r_eph;
                            r_accp  <= W'(1);
                            r_ecnt  <= '0;
                            r_state <= S_PMUL;
                        end else begin
                            r_r0 <= r_mod;
                            r_r1 <= r_accp;
                            r_t0 <= '0;
                            r_t1 <= W'(1);
                            r_state <= (r_accp == '0) ? S_FIN : S_EDIV;
                        end
                    end else begin
                        r_c1o   <= r_accp;
                        r_state <= S_FIN;
                    end
                end
                S_EDIV: r_state <= S_EDWT;
                S_EDWT: begin
                    if (w_ddone) begin
                        r_qt    <= w_dq;
                        r_r0    <= r_r1;
                        r_r1    <= w_dr;
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: r_state <= S_EMWT;
                S_EMWT: begin
                    if (w_msts.done) begin
                        // coefficients kept as residues mod p
                        r_t0 <= r_t1;
                        r_t1 <= (w_tsub >= {1'b0, r_mod}) ? W'(w_tsub - {1'b0, r_mod})
                                                          : w_tsub[W-1:0];
                        r_state <= (r_r1 == '0) ? S_FIN : S_EDIV;
                    end
                end
                S_FIN: begin
                    if (r_op && r_r0 != W'(1)) begin
                        r_c2o <= '0;
                        r_pto <= '0;
                        r_nio <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PWAIT;
                        r_pass  <= 2'd2;
                        r_phase <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_valid || i_ready) begin
                        r_o1    <= r_c1o;
                        r_o2    <= r_c2o;
                        r_osh   <= r_s;
                        r_opt   <= r_pto;
                        r_oni   <= r_nio;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_valid;
    assign o_cipher_first_out  = r_o1;
    assign o_cipher_second_out = r_o2;
    assign o_shared_key        = r_osh;
    assign o_plaintext         = r_opt;
    assign o_no_inverse        = r_oni;

    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mctl.start |-> !w_msts.busy)
        else $error("multiplier started while busy");
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_oni) |-> r_opt == '0)
        else $error("plaintext with no inverse");
    a_ready_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted item not taken");

endmodule
